// ===== rtl/xvdmt_pkg.sv =====
// Shared types and constants for the XOR-verified direct-mapped table.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package xvdmt_pkg;

  localparam int unsigned INDEX_BITS_DEFAULT = 12;
  localparam int unsigned WORD_BITS          = 64;
  localparam int unsigned SCORE_BITS         = 16;
  localparam int unsigned PACKED_SCORE_BITS  = 2 * SCORE_BITS;

  localparam logic [1:0] CMD_PROBE = 2'd0;
  localparam logic [1:0] CMD_STORE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]                   command;
    logic [WORD_BITS-1:0]         lookup_key;
    logic signed [SCORE_BITS-1:0] mid_score_in;
    logic signed [SCORE_BITS-1:0] end_score_in;
    logic [WORD_BITS-1:0]         white_mask_in;
    logic [WORD_BITS-1:0]         black_mask_in;
  } request_t;

  typedef struct packed {
    logic                         hit;
    logic signed [SCORE_BITS-1:0] mid_score_out;
    logic signed [SCORE_BITS-1:0] end_score_out;
    logic [WORD_BITS-1:0]         white_mask_out;
    logic [WORD_BITS-1:0]         black_mask_out;
  } response_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic mem_write;
    logic sweep_write;
    logic result_zero;
    logic result_probe;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       sweep_last;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/xvdmt_ram.sv =====
// Generic single-port RAM with a registered read.
// Depends on xvdmt_pkg for default sizes only.
`timescale 1ns / 1ps
`default_nettype none

module xvdmt_ram #(
  parameter int unsigned WIDTH = xvdmt_pkg::WORD_BITS,
  parameter int unsigned DEPTH = 1 << xvdmt_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/xvdmt_datapath.sv =====
// Datapath: held transaction, table memories, clearing counter, result register.
// Depends on xvdmt_pkg and xvdmt_ram.
`timescale 1ns / 1ps
`default_nettype none

module xvdmt_datapath #(
  parameter int unsigned INDEX_BITS = xvdmt_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire xvdmt_pkg::request_t  request,
  input  wire xvdmt_pkg::ctrl_t     ctrl,
  output xvdmt_pkg::status_t        status,
  output logic                      done,
  output xvdmt_pkg::response_t      result
);

  import xvdmt_pkg::*;

  localparam int unsigned DEPTH = 1 << INDEX_BITS;

  request_t                       req_q;
  logic [INDEX_BITS-1:0]          cnt;
  logic [INDEX_BITS-1:0]          addr;
  logic                           we;
  logic [WORD_BITS-1:0]           store_score;
  logic [WORD_BITS-1:0]           wr_check;
  logic [PACKED_SCORE_BITS-1:0]   wr_score;
  logic [WORD_BITS-1:0]           wr_white;
  logic [WORD_BITS-1:0]           wr_black;
  logic [WORD_BITS-1:0]           rd_check;
  logic [PACKED_SCORE_BITS-1:0]   rd_score;
  logic [WORD_BITS-1:0]           rd_white;
  logic [WORD_BITS-1:0]           rd_black;
  logic [WORD_BITS-1:0]           rd_score_word;
  response_t                      probe_result;

  // Each 16-bit score is sign-extended into its own 32-bit half.
  function automatic logic [WORD_BITS-1:0] widen_scores(
    input logic [PACKED_SCORE_BITS-1:0] packed_scores
  );
    logic [SCORE_BITS-1:0] mid_s;
    logic [SCORE_BITS-1:0] end_s;
    mid_s = packed_scores[SCORE_BITS-1:0];
    end_s = packed_scores[PACKED_SCORE_BITS-1:SCORE_BITS];
    return {{SCORE_BITS{end_s[SCORE_BITS-1]}}, end_s,
            {SCORE_BITS{mid_s[SCORE_BITS-1]}}, mid_s};
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      req_q <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.sweep_write) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign status.op         = req_q.command;
  assign status.sweep_last = &cnt;

  assign addr        = ctrl.sweep_write ? cnt : req_q.lookup_key[INDEX_BITS-1:0];
  assign we          = ctrl.mem_write | ctrl.sweep_write;
  assign store_score = widen_scores({req_q.end_score_in, req_q.mid_score_in});

  // The clearing pass writes all-zero entries, which are self-consistent.
  always_comb begin
    if (ctrl.sweep_write) begin
      wr_check = '0;
      wr_score = '0;
      wr_white = '0;
      wr_black = '0;
    end else begin
      wr_check = req_q.lookup_key ^ store_score ^ req_q.white_mask_in ^ req_q.black_mask_in;
      wr_score = {req_q.end_score_in, req_q.mid_score_in};
      wr_white = req_q.white_mask_in;
      wr_black = req_q.black_mask_in;
    end
  end

  xvdmt_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_check_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wr_check), .rdata(rd_check)
  );

  xvdmt_ram #(.WIDTH(PACKED_SCORE_BITS), .DEPTH(DEPTH)) u_score_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wr_score), .rdata(rd_score)
  );

  xvdmt_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_white_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wr_white), .rdata(rd_white)
  );

  xvdmt_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_black_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wr_black), .rdata(rd_black)
  );

  assign rd_score_word = widen_scores(rd_score);

  always_comb begin
    probe_result = '0;
    if ((rd_check ^ rd_score_word ^ rd_white ^ rd_black) == req_q.lookup_key) begin
      probe_result.hit            = 1'b1;
      probe_result.mid_score_out  = rd_score[SCORE_BITS-1:0];
      probe_result.end_score_out  = rd_score[PACKED_SCORE_BITS-1:SCORE_BITS];
      probe_result.white_mask_out = rd_white;
      probe_result.black_mask_out = rd_black;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.result_zero | ctrl.result_probe;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.result_zero) begin
      result <= '0;
    end else if (ctrl.result_probe) begin
      result <= probe_result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/xvdmt_controller.sv =====
// Controller state machine: sequences probe, store and the clearing pass.
// Depends on xvdmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xvdmt_controller (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire xvdmt_pkg::status_t  status,
  output xvdmt_pkg::ctrl_t         ctrl,
  output logic                     busy
);

  import xvdmt_pkg::*;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state;
  logic   report;
  logic   accept;

  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_SWEEP;
      busy   <= 1'b1;
      report <= 1'b0;
    end else begin
      unique case (state)
        S_SWEEP: begin
          if (status.sweep_last) begin
            state  <= S_IDLE;
            busy   <= 1'b0;
            report <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          if (status.op == CMD_CLEAR) begin
            state  <= S_SWEEP;
            report <= 1'b1;
          end else if (status.op == CMD_PROBE) begin
            state <= S_RESP;
            busy  <= 1'b0;
          end else begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_RESP: begin
          if (accept) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    ctrl           = '0;
    ctrl.load_item = accept;
    unique case (state)
      S_SWEEP: begin
        ctrl.sweep_write = 1'b1;
        ctrl.result_zero = status.sweep_last & report;
      end
      S_EXEC: begin
        unique case (status.op)
          CMD_PROBE: ctrl.result_zero = 1'b0;
          CMD_STORE: begin
            ctrl.mem_write   = 1'b1;
            ctrl.result_zero = 1'b1;
          end
          CMD_CLEAR: ctrl.result_zero = 1'b0;
          default:   ctrl.result_zero = 1'b1;
        endcase
      end
      S_RESP:  ctrl.result_probe = 1'b1;
      default: ctrl.result_probe = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/xor_verified_direct_mapped_table_top.sv =====
// Top level of the XOR-verified direct-mapped table: controller plus datapath.
// Depends on xvdmt_pkg, xvdmt_controller, xvdmt_datapath (and xvdmt_ram below it).
// Sequence: a store or an unused command shows its result strobe after the execute
// state; a probe after the execute state, the registered read on the single table port
// and the check compare in the response state; a clear after the execute state and the
// whole clearing pass. No new transaction is taken while one executes. The receiver
// cannot stall. Reset: busy stays high through a clearing pass over the whole table.
`timescale 1ns / 1ps
`default_nettype none

module xor_verified_direct_mapped_table_top #(
  parameter int unsigned INDEX_BITS = xvdmt_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire xvdmt_pkg::request_t  request,
  output logic                      busy,
  output logic                      done,
  output xvdmt_pkg::response_t      result
);

  import xvdmt_pkg::*;

  // A transaction is accepted when start is high and busy is low. The
  // datapath captures the request at that edge and holds it until the next
  // accepted transaction, so the request port only has to be valid at the
  // accepting edge.
  ctrl_t   ctrl;
  status_t status;

  // The controller decides the sequence: an execute cycle that either reads
  // the entry (probe), writes it (store) or starts a clearing pass (clear),
  // then a response cycle for probes in which a new transaction may already
  // be accepted.
  xvdmt_controller u_controller (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // The datapath holds the four table memories. Entries are never tagged as
  // valid; instead the clearing pass after reset and after a clear command
  // writes all-zero entries, which check correctly against key zero. Each
  // result is registered and shown for exactly one cycle with done high.
  xvdmt_datapath #(
    .INDEX_BITS(INDEX_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .request(request),
    .ctrl   (ctrl),
    .status (status),
    .done   (done),
    .result (result)
  );

endmodule

`default_nettype wire

// ===== rtl/xvdmt_checker.sv =====
// Port-level checker for the XOR-verified direct-mapped table, bound to the top.
// Depends on xvdmt_pkg and xor_verified_direct_mapped_table_top.
`timescale 1ns / 1ps
`default_nettype none

module xvdmt_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire xvdmt_pkg::request_t  request,
  input wire logic                 busy,
  input wire logic                 done,
  input wire xvdmt_pkg::response_t result
);

  import xvdmt_pkg::*;

  // Reset starts the clearing pass: busy and no result.
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> (busy && !done))
    else $error("reset did not start clearing pass");

  // An accepted transaction makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // A clear keeps the block busy through the execute state and into the clearing pass.
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command == CMD_CLEAR) |=> busy ##1 busy)
    else $error("clear released busy too early");

  // A result without a hit carries all-zero fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.hit) |-> (result.mid_score_out == '0 &&
      result.end_score_out == '0 && result.white_mask_out == '0 &&
      result.black_mask_out == '0))
    else $error("non-hit result carries data");

endmodule

bind xor_verified_direct_mapped_table_top xvdmt_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .request(request),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
